### sv/ptc_pkg.sv
// Shared constants, types and multiplier helpers for the pressure and temperature compensation.
package ptc_pkg;

    localparam int RAW_W   = 20;
    localparam int WORD_W  = 32;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 31;
    localparam int CFG_W   = 64;

    localparam logic [1:0] CFG_TEMP   = 2'd0;
    localparam logic [1:0] CFG_PLOW   = 2'd1;
    localparam logic [1:0] CFG_PHIGH  = 2'd2;
    localparam logic [1:0] CFG_PNINE  = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] tc;
        logic [WORD_W-1:0] fine;
    } t_div_side;

    // Lower 32-bit half of a 64-bit word times a 17-bit signed factor, extended to 64 bits.
    function automatic logic [63:0] f_mul_lo(input logic [31:0] x, input logic signed [16:0] c);
        logic signed [49:0] prod;
        prod = $signed({1'b0, x}) * c;
        return {{14{prod[49]}}, prod};
    endfunction

    // Upper 32-bit half times the factor; only the low 32 bits reach a 64-bit result.
    function automatic logic [31:0] f_mul_hi(input logic [31:0] x, input logic signed [16:0] c);
        logic signed [48:0] prod;
        prod = $signed(x) * c;
        return prod[31:0];
    endfunction

    // Temperature in hundredths of a degree from the fine temperature.
    function automatic logic [31:0] f_centi(input logic [31:0] f);
        logic        [31:0] s;
        logic signed [31:0] sh;
        s  = {f[29:0], 2'b00} + f + 32'd128;
        sh = $signed(s) >>> 8;
        return sh;
    endfunction

endpackage

### sv/pressure_temperature_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
// The slave stream takes one word per sample: raw temperature and raw pressure.
// The master stream returns one word per sample: temperature in hundredths of a
// degree, the fine temperature and the pressure in pascals.
// Calibration words are loaded through the write port; the user must load them only
// while no sample is in flight, as the block itself does not enforce this.
// A word passes 85 register stages, the first loaded at the accepting edge: twelve
// stages of polynomial work, 66 stages of the bit-per-stage divider and seven
// stages of pressure correction and output.
// Throughput is one word per cycle; every stage holds its own sample and valid bit.
// When the receiver holds m_tready low with a result waiting, the whole pipeline
// freezes and s_tready falls in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets every calibration register to zero.
// A zero divisor in the pressure path gives a pressure of zero; both temperature
// fields are still delivered.
module pressure_temperature_compensation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [19:0] raw_temperature, [39:20] raw_pressure
    input  logic [39:0]                 s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [31:0] temperature_centi, [63:32] fine_temperature, [95:64] pressure
    output logic [95:0]                 m_tdata,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_addr,
    input  logic [ptc_pkg::CFG_W-1:0]   i_cfg_data
);
    import ptc_pkg::*;

    logic [47:0] r_cfg_temp;
    logic [63:0] r_cfg_plow;
    logic [63:0] r_cfg_phigh;
    logic [15:0] r_cfg_pnine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_temp  <= '0;
            r_cfg_plow  <= '0;
            r_cfg_phigh <= '0;
            r_cfg_pnine <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TEMP:  r_cfg_temp  <= i_cfg_data[47:0];
                CFG_PLOW:  r_cfg_plow  <= i_cfg_data;
                CFG_PHIGH: r_cfg_phigh <= i_cfg_data;
                CFG_PNINE: r_cfg_pnine <= i_cfg_data[15:0];
            endcase
        end
    end

    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = r_cfg_temp[15:0];
    assign t2 = r_cfg_temp[31:16];
    assign t3 = r_cfg_temp[47:32];
    assign p1 = r_cfg_plow[15:0];
    assign p2 = r_cfg_plow[31:16];
    assign p3 = r_cfg_plow[47:32];
    assign p4 = r_cfg_plow[63:48];
    assign p5 = r_cfg_phigh[15:0];
    assign p6 = r_cfg_phigh[31:16];
    assign p7 = r_cfg_phigh[47:32];
    assign p8 = r_cfg_phigh[63:48];
    assign p9 = r_cfg_pnine;

    logic en;
    logic r_o_valid;
    assign en       = !r_o_valid || m_tready;
    assign s_tready = en;

    logic [12:1] r_vld_pre;
    logic [6:1]  r_vld_post;
    logic        div_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pre  <= '0;
            r_vld_post <= '0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_vld_pre  <= {r_vld_pre[11:1], s_tvalid};
            r_vld_post <= {r_vld_post[5:1], div_valid};
            r_o_valid  <= r_vld_post[6];
        end
    end

    // Temperature polynomial
    logic signed [17:0] n1_x;
    logic signed [16:0] n1_d;
    logic signed [17:0] r1_x;
    logic signed [16:0] r1_d;
    logic [RAW_W-1:0]   r_adp [1:9];
    assign n1_x = $signed({1'b0, s_tdata[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign n1_d = $signed({1'b0, s_tdata[19:4]}) - $signed({1'b0, t1});

    logic signed [33:0] prod_a;
    logic signed [33:0] prod_dd;
    logic [31:0]        r2_araw;
    logic [31:0]        r2_dd;
    assign prod_a  = r1_x * t2;
    assign prod_dd = r1_d * r1_d;

    logic signed [31:0] dd_sh;
    logic signed [47:0] prod_b;
    logic signed [31:0] n3_a;
    logic [31:0]        r3_braw;
    logic signed [31:0] r3_a;
    assign dd_sh  = $signed(r2_dd) >>> 12;
    assign prod_b = dd_sh * t3;
    assign n3_a   = $signed(r2_araw) >>> 11;

    logic signed [31:0] b_sh;
    logic [31:0]        r4_fine;
    assign b_sh = $signed(r3_braw) >>> 14;

    // Pressure polynomial
    logic signed [32:0] n5_v1;
    logic signed [32:0] r5_v1;
    t_div_side          r_pside [5:12];
    assign n5_v1 = $signed({r4_fine[31], r4_fine}) - 33'sd128000;

    logic signed [65:0] vsq_full;
    logic signed [48:0] n6_vp5, n6_vp2;
    logic [63:0]        r6_vsq;
    logic signed [48:0] r6_vp5, r6_vp2;
    assign vsq_full = r5_v1 * r5_v1;
    assign n6_vp5   = r5_v1 * p5;
    assign n6_vp2   = r5_v1 * p2;

    logic [63:0] r7_q6lo, r7_q3lo, r7_vp5s, r7_vp2s;
    logic [31:0] r7_q6hi, r7_q3hi;

    logic [63:0] r8_v2a, r8_v1a, r8_vp5s, r8_vp2s;

    logic [63:0]        p4s;
    logic signed [63:0] v1a_sh;
    logic [63:0]        r9_v2, r9_v1b;
    assign p4s    = {{48{p4[15]}}, p4} << 35;
    assign v1a_sh = $signed(r8_v1a) >>> 8;

    logic [20:0] praw;
    logic [63:0] r10_mlo, r10_num0;
    logic [31:0] r10_mhi;
    assign praw = 21'h100000 - {1'b0, r_adp[9]};

    logic [63:0]        m_sum;
    logic [DIV_D_W-1:0] r11_den;
    logic [63:0]        r11_nlo;
    logic [31:0]        r11_nhi;
    assign m_sum = r10_mlo + {r10_mhi, 32'b0} + ({48'b0, p1} << 47);

    logic [63:0]        r12_num;
    logic [DIV_D_W-1:0] r12_den;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x     <= n1_x;
            r1_d     <= n1_d;
            r_adp[1] <= s_tdata[39:20];
            for (int k = 2; k <= 9; k++) begin
                r_adp[k] <= r_adp[k-1];
            end

            r2_araw <= prod_a[31:0];
            r2_dd   <= prod_dd[31:0];

            r3_braw <= prod_b[31:0];
            r3_a    <= n3_a;

            r4_fine <= r3_a + b_sh;

            r5_v1           <= n5_v1;
            r_pside[5].tc   <= f_centi(r4_fine);
            r_pside[5].fine <= r4_fine;
            for (int k = 6; k <= 12; k++) begin
                r_pside[k] <= r_pside[k-1];
            end

            r6_vsq <= vsq_full[63:0];
            r6_vp5 <= n6_vp5;
            r6_vp2 <= n6_vp2;

            r7_q6lo <= f_mul_lo(r6_vsq[31:0], {p6[15], p6});
            r7_q6hi <= f_mul_hi(r6_vsq[63:32], {p6[15], p6});
            r7_q3lo <= f_mul_lo(r6_vsq[31:0], {p3[15], p3});
            r7_q3hi <= f_mul_hi(r6_vsq[63:32], {p3[15], p3});
            r7_vp5s <= {{15{r6_vp5[48]}}, r6_vp5} << 17;
            r7_vp2s <= {{15{r6_vp2[48]}}, r6_vp2} << 12;

            r8_v2a  <= r7_q6lo + {r7_q6hi, 32'b0};
            r8_v1a  <= r7_q3lo + {r7_q3hi, 32'b0};
            r8_vp5s <= r7_vp5s;
            r8_vp2s <= r7_vp2s;

            r9_v2  <= r8_v2a + r8_vp5s + p4s;
            r9_v1b <= v1a_sh + r8_vp2s;

            r10_mlo  <= f_mul_lo(r9_v1b[31:0], {1'b0, p1});
            r10_mhi  <= f_mul_hi(r9_v1b[63:32], {1'b0, p1});
            r10_num0 <= ({43'b0, praw} << 31) - r9_v2;

            r11_den <= m_sum[63:33];
            r11_nlo <= f_mul_lo(r10_num0[31:0], 17'sd3125);
            r11_nhi <= f_mul_hi(r10_num0[63:32], 17'sd3125);

            r12_num <= r11_nlo + {r11_nhi, 32'b0};
            r12_den <= r11_den;
        end
    end

    logic [63:0] div_quo;
    logic        div_zero;
    t_div_side   div_side;

    ptc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld_pre[12]),
        .i_num   (r12_num),
        .i_den   (r12_den),
        .i_side  (r_pside[12]),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_zero  (div_zero),
        .o_side  (div_side)
    );

    // Pressure correction after the division
    t_div_side r_qside [1:6];
    logic      r_qzero [1:6];

    logic signed [63:0] ps;
    logic [63:0]        r_a1_p, r_a1_ps, r_a1_k9lo, r_a1_k8lo;
    logic [31:0]        r_a1_k9hi, r_a1_k8hi;
    assign ps = $signed(div_quo) >>> 13;

    logic [63:0]        k8_sum;
    logic signed [63:0] w2_sh;
    logic [63:0]        r_a2_p, r_a2_ps, r_a2_m1, r_a2_w2;
    assign k8_sum = r_a1_k8lo + {r_a1_k8hi, 32'b0};
    assign w2_sh  = $signed(k8_sum) >>> 19;

    logic [63:0] pl_ll, pl_lh, pl_hl;
    logic [63:0] r_a3_p, r_a3_w2, r_a3_ll;
    logic [31:0] r_a3_lh, r_a3_hl;
    assign pl_ll = r_a2_m1[31:0] * r_a2_ps[31:0];
    assign pl_lh = r_a2_m1[31:0] * r_a2_ps[63:32];
    assign pl_hl = r_a2_m1[63:32] * r_a2_ps[31:0];

    logic [63:0]        w1_sum;
    logic signed [63:0] w1_sh;
    logic [63:0]        r_a4_p, r_a4_w2, r_a4_w1;
    assign w1_sum = r_a3_ll + {r_a3_lh + r_a3_hl, 32'b0};
    assign w1_sh  = $signed(w1_sum) >>> 25;

    logic [63:0] r_a5_s;

    logic signed [63:0] s_sh;
    logic [63:0]        p7s;
    logic [63:0]        r_a6_s2;
    assign s_sh = $signed(r_a5_s) >>> 8;
    assign p7s  = {{48{p7[15]}}, p7} << 4;

    logic [63:0]        rnd;
    logic signed [63:0] q256;
    logic [31:0]        r_o_tc, r_o_fine, r_o_pres;
    logic               r_o_zero;
    assign rnd  = r_a6_s2 + (r_a6_s2[63] ? 64'd255 : 64'd0);
    assign q256 = $signed(rnd) >>> 8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qside[1] <= div_side;
            r_qzero[1] <= div_zero;
            for (int k = 2; k <= 6; k++) begin
                r_qside[k] <= r_qside[k-1];
                r_qzero[k] <= r_qzero[k-1];
            end

            r_a1_p    <= div_quo;
            r_a1_ps   <= ps;
            r_a1_k9lo <= f_mul_lo(ps[31:0], {p9[15], p9});
            r_a1_k9hi <= f_mul_hi(ps[63:32], {p9[15], p9});
            r_a1_k8lo <= f_mul_lo(div_quo[31:0], {p8[15], p8});
            r_a1_k8hi <= f_mul_hi(div_quo[63:32], {p8[15], p8});

            r_a2_p  <= r_a1_p;
            r_a2_ps <= r_a1_ps;
            r_a2_m1 <= r_a1_k9lo + {r_a1_k9hi, 32'b0};
            r_a2_w2 <= w2_sh;

            r_a3_p  <= r_a2_p;
            r_a3_w2 <= r_a2_w2;
            r_a3_ll <= pl_ll;
            r_a3_lh <= pl_lh[31:0];
            r_a3_hl <= pl_hl[31:0];

            r_a4_p  <= r_a3_p;
            r_a4_w2 <= r_a3_w2;
            r_a4_w1 <= w1_sh;

            r_a5_s <= r_a4_p + r_a4_w1 + r_a4_w2;

            r_a6_s2 <= s_sh + p7s;

            r_o_tc   <= r_qside[6].tc;
            r_o_fine <= r_qside[6].fine;
            r_o_zero <= r_qzero[6];
            r_o_pres <= r_qzero[6] ? 32'd0 : q256[31:0];
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = {r_o_pres, r_o_fine, r_o_tc};

    a_centi_matches_fine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_tc == f_centi(r_o_fine)))
        else $error("temperature and fine temperature of one word disagree");

    a_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_zero) |-> (r_o_pres == 32'd0))
        else $error("pressure not zero for a zero divisor");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_pre[12] && !en) |=> r_vld_pre[12])
        else $error("pipeline moved while the output was stalled");

endmodule

### sv/ptc_divider.sv
// Pipelined signed 64 by 31 bit divider, one quotient bit per stage, rounding toward zero.
module ptc_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [ptc_pkg::DIV_N_W-1:0]   i_num,
    input  logic [ptc_pkg::DIV_D_W-1:0]   i_den,
    input  ptc_pkg::t_div_side            i_side,
    output logic                          o_valid,
    output logic [ptc_pkg::DIV_N_W-1:0]   o_quo,
    output logic                          o_zero,
    output ptc_pkg::t_div_side            o_side
);
    import ptc_pkg::*;

    localparam int STAGES = DIV_N_W;

    logic [STAGES:0]      r_vld;
    logic [DIV_N_W-1:0]   r_num  [0:STAGES];
    logic [DIV_D_W-1:0]   r_rem  [0:STAGES];
    logic [DIV_D_W-1:0]   r_den  [0:STAGES];
    logic                 r_neg  [0:STAGES];
    logic                 r_zero [0:STAGES];
    t_div_side            r_side [0:STAGES];
    logic                 r_out_valid;
    logic [DIV_N_W-1:0]   r_out_quo;
    logic                 r_out_zero;
    t_div_side            r_out_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_vld       <= {r_vld[STAGES-1:0], i_valid};
            r_out_valid <= r_vld[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= i_num[DIV_N_W-1] ? (DIV_N_W'(0) - i_num) : i_num;
            r_den[0]  <= i_den[DIV_D_W-1] ? (DIV_D_W'(0) - i_den) : i_den;
            r_rem[0]  <= '0;
            r_neg[0]  <= i_num[DIV_N_W-1] ^ i_den[DIV_D_W-1];
            r_zero[0] <= (i_den == '0);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= STAGES; k++) begin : g_step
        logic [DIV_D_W:0] trial;
        logic [DIV_D_W:0] diff;
        logic             ge;
        assign trial = {r_rem[k-1], r_num[k-1][DIV_N_W-1]};
        assign ge    = (trial >= {1'b0, r_den[k-1]});
        assign diff  = trial - {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
                r_num[k]  <= {r_num[k-1][DIV_N_W-2:0], ge};
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_quo  <= r_neg[STAGES] ? (DIV_N_W'(0) - r_num[STAGES]) : r_num[STAGES];
            r_out_zero <= r_zero[STAGES];
            r_out_side <= r_side[STAGES];
        end
    end

    assign o_valid = r_out_valid;
    assign o_quo   = r_out_quo;
    assign o_zero  = r_out_zero;
    assign o_side  = r_out_side;

endmodule
